>>> design/cordic_sine_cosine_defines.svh
// Assertion macros shared by the CORDIC sine and cosine design.
// Stands alone; included by cordic_sine_cosine.sv, the file that carries the concurrent assertions.
`ifndef CORDIC_SINE_COSINE_DEFINES_SVH
`define CORDIC_SINE_COSINE_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define CSC_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("CORDIC sine and cosine check failed");

// Next-cycle implication, disabled while reset is high.
`define CSC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("CORDIC sine and cosine check failed");

`endif

>>> design/csc_pkg.sv
// Package for the CORDIC sine and cosine pipeline: widths, angle constants,
// the arctangent table and the stage payload type. Depends on nothing.
package csc_pkg;

   localparam int ANGLE_W      = 32;
   localparam int CMD_W        = 1;
   localparam int OUT_W        = 34;
   localparam int IN_TDATA_W   = 32;
   localparam int OUT_TDATA_W  = 40;
   localparam int ITERATIONS   = 28;
   localparam int ITER_IDX_W   = 5;
   localparam int SUM_W        = ANGLE_W + 1;
   localparam int RED_W        = 31;
   localparam int WIDE_W       = SUM_W + 2;
   localparam int Z_SHIFT      = 4;
   localparam int Z_W          = RED_W + Z_SHIFT + 1;
   localparam int XY_W         = 36;
   localparam int ATAN_W       = 32;

   localparam logic [RED_W-1:0] PI_A    = 31'd843314857;
   localparam logic [RED_W-1:0] HALF_A  = 31'd421657428;
   localparam logic [RED_W-1:0] THREE_A = 31'd1264972285;
   localparam logic [RED_W-1:0] TWO_A   = 31'd1686629713;

   localparam logic signed [XY_W-1:0]  GAIN_X  = 36'sd2608131496;
   localparam logic signed [OUT_W-1:0] ONE_OUT = 34'sd4294967296;
   localparam logic signed [Z_W-1:0]   Z_HALF  = $signed({1'b0, HALF_A, {Z_SHIFT{1'b0}}});

   typedef enum logic [1:0] {
      SP_NONE,
      SP_ZERO,
      SP_POS_ONE,
      SP_NEG_ONE
   } csc_special_type;

   typedef struct packed {
      logic signed [XY_W-1:0] x;
      logic signed [XY_W-1:0] y;
      logic signed [Z_W-1:0]  z;
      logic                   neg;
      csc_special_type        special;
   } csc_stage_type;

   function automatic logic [ATAN_W-1:0] atan_q32(input logic [ITER_IDX_W-1:0] idx);
      logic [ATAN_W-1:0] v;
      unique case (idx)
         5'd0:  v = 32'd3373259426;
         5'd1:  v = 32'd1991351318;
         5'd2:  v = 32'd1052175346;
         5'd3:  v = 32'd534100635;
         5'd4:  v = 32'd268086748;
         5'd5:  v = 32'd134174063;
         5'd6:  v = 32'd67103403;
         5'd7:  v = 32'd33553749;
         5'd8:  v = 32'd16777131;
         5'd9:  v = 32'd8388597;
         5'd10: v = 32'd4194303;
         5'd11: v = 32'd2097152;
         5'd12: v = 32'd1048576;
         5'd13: v = 32'd524288;
         5'd14: v = 32'd262144;
         5'd15: v = 32'd131072;
         5'd16: v = 32'd65536;
         5'd17: v = 32'd32768;
         5'd18: v = 32'd16384;
         5'd19: v = 32'd8192;
         5'd20: v = 32'd4096;
         5'd21: v = 32'd2048;
         5'd22: v = 32'd1024;
         5'd23: v = 32'd512;
         5'd24: v = 32'd256;
         5'd25: v = 32'd128;
         5'd26: v = 32'd64;
         5'd27: v = 32'd32;
         5'd28: v = 32'd16;
         5'd29: v = 32'd8;
         5'd30: v = 32'd4;
         default: v = 32'd2;
      endcase
      return v;
   endfunction

endpackage

>>> design/cordic_sine_cosine.sv
// CORDIC sine and cosine: 32 register stages (offset add, reduction, fold,
// 28 rotation stages, output register).
// Throughput is one beat per cycle; each stage stalls only when it is full and
// the stage after it cannot take data, so bubbles close up under backpressure.
// Synchronous active-high reset clears all valid bits; data registers are not reset.
`include "cordic_sine_cosine_defines.svh"

module cordic_sine_cosine (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [csc_pkg::IN_TDATA_W-1:0]     req_tdata,   // [31:0] angle
   input  logic [csc_pkg::CMD_W-1:0]          req_tuser,   // [0] cmd
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [csc_pkg::OUT_TDATA_W-1:0]    rsp_tdata    // [33:0] value, zero padded
);
   import csc_pkg::*;

   logic                    s0_valid_ff, s0_valid_in, s0_ready;
   logic signed [SUM_W-1:0] s0_a_ff, s0_a_in;
   logic                    s1_valid_ff, s1_valid_in, s1_ready;
   logic [RED_W-1:0]        s1_r_ff, s1_r_in;
   logic                    s2_valid_ff, s2_valid_in, s2_ready;
   csc_stage_type           s2_data_ff, s2_data_in;
   logic                    rsp_valid_ff, rsp_valid_in, out_ready;
   logic signed [OUT_W-1:0] rsp_value_ff, rsp_value_in;

   logic [ITERATIONS:0]     rot_valid;
   logic [ITERATIONS:0]     rot_ready;
   csc_stage_type           rot_data [0:ITERATIONS];

   logic signed [SUM_W-1:0]  angle_ext;
   logic [SUM_W-1:0]         offset;
   logic signed [WIDE_W-1:0] a_wide, two_wide, c_plus1, c_plus2, c_minus1;
   logic [RED_W-1:0]         r_fold;
   csc_stage_type            last;

   // Offset stage: sign-extend the angle and add pi/2 for cosine.
   assign s0_ready    = !s0_valid_ff || s1_ready;
   assign s0_valid_in = s0_ready ? req_tvalid : s0_valid_ff;
   assign req_tready  = s0_ready;

   always_comb begin
      angle_ext = $signed({req_tdata[ANGLE_W-1], req_tdata});
      offset    = req_tuser[0] ? {{(SUM_W - RED_W){1'b0}}, HALF_A} : '0;
      s0_a_in   = angle_ext + $signed(offset);
   end

   // Reduction stage: the floored remainder needs one of four multiples of two pi.
   assign s1_ready    = !s1_valid_ff || s2_ready;
   assign s1_valid_in = s1_ready ? s0_valid_ff : s1_valid_ff;

   always_comb begin
      a_wide   = {{(WIDE_W - SUM_W){s0_a_ff[SUM_W-1]}}, s0_a_ff};
      two_wide = $signed({{(WIDE_W - RED_W){1'b0}}, TWO_A});
      c_plus1  = a_wide + two_wide;
      c_plus2  = a_wide + (two_wide <<< 1);
      c_minus1 = a_wide - two_wide;
      priority if (a_wide < 0 && c_plus1 >= 0) begin
         s1_r_in = c_plus1[RED_W-1:0];
      end else if (a_wide < 0) begin
         s1_r_in = c_plus2[RED_W-1:0];
      end else if (a_wide >= two_wide) begin
         s1_r_in = c_minus1[RED_W-1:0];
      end else begin
         s1_r_in = a_wide[RED_W-1:0];
      end
   end

   // Fold stage: fold into the first quadrant; pi/2 multiples get fixed results.
   assign s2_ready    = !s2_valid_ff || rot_ready[0];
   assign s2_valid_in = s2_ready ? s1_valid_ff : s2_valid_ff;

   always_comb begin
      s2_data_in     = '0;
      s2_data_in.x   = GAIN_X;
      s2_data_in.y   = '0;
      r_fold         = s1_r_ff;
      s2_data_in.neg = 1'b0;
      priority if (s1_r_ff == '0 || s1_r_ff == PI_A) begin
         s2_data_in.special = SP_ZERO;
      end else if (s1_r_ff == HALF_A) begin
         s2_data_in.special = SP_POS_ONE;
      end else if (s1_r_ff == THREE_A) begin
         s2_data_in.special = SP_NEG_ONE;
      end else begin
         s2_data_in.special = SP_NONE;
      end
      priority if (s1_r_ff <= PI_A && s1_r_ff > HALF_A) begin
         r_fold = PI_A - s1_r_ff;
      end else if (s1_r_ff > PI_A && s1_r_ff <= THREE_A) begin
         r_fold         = s1_r_ff - PI_A;
         s2_data_in.neg = 1'b1;
      end else if (s1_r_ff > THREE_A) begin
         r_fold         = TWO_A - s1_r_ff;
         s2_data_in.neg = 1'b1;
      end else begin
         r_fold = s1_r_ff;
      end
      s2_data_in.z = $signed({1'b0, r_fold, {Z_SHIFT{1'b0}}});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff  <= 1'b0;
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s0_valid_ff  <= s0_valid_in;
         s1_valid_ff  <= s1_valid_in;
         s2_valid_ff  <= s2_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s0_ready && req_tvalid) begin
         s0_a_ff <= s0_a_in;
      end
      if (s1_ready && s0_valid_ff) begin
         s1_r_ff <= s1_r_in;
      end
      if (s2_ready && s1_valid_ff) begin
         s2_data_ff <= s2_data_in;
      end
      if (out_ready && rot_valid[ITERATIONS]) begin
         rsp_value_ff <= rsp_value_in;
      end
   end

   // Rotation stages.
   assign rot_valid[0] = s2_valid_ff;
   assign rot_data[0]  = s2_data_ff;

   for (genvar i = 0; i < ITERATIONS; i++) begin : g_rot
      csc_rotator u_rot (
         .clock     (clock),
         .reset     (reset),
         .iter      (ITER_IDX_W'(i)),
         .in_valid  (rot_valid[i]),
         .in_ready  (rot_ready[i]),
         .in_data   (rot_data[i]),
         .out_valid (rot_valid[i+1]),
         .out_ready (rot_ready[i+1]),
         .out_data  (rot_data[i+1])
      );
   end

   // Output register.
   assign out_ready             = !rsp_valid_ff || rsp_tready;
   assign rot_ready[ITERATIONS] = out_ready;
   assign rsp_valid_in          = out_ready ? rot_valid[ITERATIONS] : rsp_valid_ff;

   always_comb begin
      last = rot_data[ITERATIONS];
      unique case (last.special)
         SP_NONE:    rsp_value_in = last.neg ? -last.y[OUT_W-1:0] : last.y[OUT_W-1:0];
         SP_ZERO:    rsp_value_in = '0;
         SP_POS_ONE: rsp_value_in = ONE_OUT;
         SP_NEG_ONE: rsp_value_in = -ONE_OUT;
         default:    rsp_value_in = '0;
      endcase
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(OUT_TDATA_W - OUT_W){1'b0}}, rsp_value_ff};

   `CSC_ASSERT_SAME(a_full_when_stalled, clock, reset, !req_tready, s0_valid_ff && s1_valid_ff && s2_valid_ff && (&rot_valid[ITERATIONS:1]) && rsp_valid_ff)
   `CSC_ASSERT_SAME(a_reduced_in_range, clock, reset, s1_valid_ff, s1_r_ff < TWO_A)
   `CSC_ASSERT_SAME(a_folded_in_quadrant, clock, reset, s2_valid_ff && s2_data_ff.special == SP_NONE, s2_data_ff.z > 0 && s2_data_ff.z <= Z_HALF)
   `CSC_ASSERT_NEXT(a_output_held, clock, reset, rsp_valid_ff && !rsp_tready, rsp_valid_ff && $stable(rsp_value_ff))

endmodule

>>> design/csc_rotator.sv
// One CORDIC rotation stage with its own valid bit and ready chain.
// Depends on csc_pkg for the payload type and the arctangent table.
module csc_rotator (
   input  logic                           clock,
   input  logic                           reset,
   input  logic [csc_pkg::ITER_IDX_W-1:0] iter,
   input  logic                           in_valid,
   output logic                           in_ready,
   input  csc_pkg::csc_stage_type         in_data,
   output logic                           out_valid,
   input  logic                           out_ready,
   output csc_pkg::csc_stage_type         out_data
);
   import csc_pkg::*;

   logic                   valid_ff;
   logic                   valid_in;
   csc_stage_type          data_ff;
   csc_stage_type          data_in;
   logic signed [XY_W-1:0] x_sh;
   logic signed [XY_W-1:0] y_sh;
   logic signed [Z_W-1:0]  atan_v;

   assign in_ready = !valid_ff || out_ready;
   assign valid_in = in_ready ? in_valid : valid_ff;

   always_comb begin
      x_sh    = in_data.x >>> iter;
      y_sh    = in_data.y >>> iter;
      atan_v  = $signed({{(Z_W - ATAN_W){1'b0}}, atan_q32(iter)});
      data_in = in_data;
      if (in_data.z > 0) begin
         data_in.x = in_data.x - y_sh;
         data_in.y = in_data.y + x_sh;
         data_in.z = in_data.z - atan_v;
      end else begin
         data_in.x = in_data.x + y_sh;
         data_in.y = in_data.y - x_sh;
         data_in.z = in_data.z + atan_v;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule
